// ===== rtl/lvdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lvdq_pkg;

    localparam int FRAC_BITS = 24;
    localparam int X_W       = 26;
    localparam int ORDER_W   = 5;
    localparam int VAL_W     = 26;
    localparam int SLOPE_W   = 33;
    localparam int QV_W      = 27;
    localparam int QS_W      = 34;
    localparam int ADDR_W    = 2;
    localparam int DATA_W    = 32;

    localparam int DEF_MAX_ORDER = 16;

    // Internal value and operand widths.
    localparam int L_W    = 30;
    localparam int OPA_W  = 27;
    localparam int COEF_W = 26;
    localparam int PROD_W = OPA_W + L_W;

    localparam longint ONE_Q24   = 64'sd16777216;
    localparam longint VAL_LIM   = 64'sd16777216;
    localparam longint SLOPE_LIM = 64'sd2281701376;
    localparam longint QV_LIM    = 64'sd33554432;
    localparam longint QS_LIM    = 64'sd4580179968;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd2;
    localparam logic [ADDR_W-1:0]  REG_ORDER   = 2'd0;

    // Multiplier operand selects.
    localparam logic [1:0] ASEL_COEF_A = 2'd0;
    localparam logic [1:0] ASEL_COEF_B = 2'd1;
    localparam logic [1:0] ASEL_ODD    = 2'd2;
    localparam logic [1:0] ASEL_AX     = 2'd3;

    localparam logic [1:0] BSEL_X   = 2'd0;
    localparam logic [1:0] BSEL_LM1 = 2'd1;
    localparam logic [1:0] BSEL_LM2 = 2'd2;
    localparam logic [1:0] BSEL_NONE = 2'd3;

    // Write-back operations.
    localparam logic [2:0] WB_NONE   = 3'd0;
    localparam logic [2:0] WB_AX     = 3'd1;
    localparam logic [2:0] WB_T      = 3'd2;
    localparam logic [2:0] WB_L      = 3'd3;
    localparam logic [2:0] WB_COMMIT = 3'd4;
    localparam logic [2:0] WB_FINISH = 3'd5;

    // Sequencing.
    localparam logic [1:0] JMP_NEXT = 2'd0;
    localparam logic [1:0] JMP_LOOP = 2'd1;
    localparam logic [1:0] JMP_WAIT = 2'd2;
    localparam logic [1:0] JMP_END  = 2'd3;

    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_ENTRY  = 3'd0;
    localparam logic [PC_W-1:0] PC_MULB   = 3'd1;
    localparam logic [PC_W-1:0] PC_MULAXL = 3'd2;
    localparam logic [PC_W-1:0] PC_MULODD = 3'd3;
    localparam logic [PC_W-1:0] PC_COMMIT = 3'd4;
    localparam logic [PC_W-1:0] PC_FINISH = 3'd5;

    typedef struct packed {
        logic [1:0] a_sel;
        logic [1:0] b_sel;
        logic [2:0] wb;
        logic [1:0] jmp;
        logic       coef_next;
    } uc_word_t;

    function automatic uc_word_t uc_rom(input logic [PC_W-1:0] pc);
        uc_word_t w;
        w = '{a_sel: ASEL_COEF_A, b_sel: BSEL_NONE, wb: WB_NONE, jmp: JMP_END,
              coef_next: 1'b0};
        case (pc)
            PC_ENTRY:
            begin
                w = '{a_sel: ASEL_COEF_A, b_sel: BSEL_X, wb: WB_NONE, jmp: JMP_NEXT,
                      coef_next: 1'b0};
            end
            PC_MULB:
            begin
                w = '{a_sel: ASEL_COEF_B, b_sel: BSEL_LM2, wb: WB_AX, jmp: JMP_NEXT,
                      coef_next: 1'b0};
            end
            PC_MULAXL:
            begin
                w = '{a_sel: ASEL_AX, b_sel: BSEL_LM1, wb: WB_T, jmp: JMP_NEXT,
                      coef_next: 1'b0};
            end
            PC_MULODD:
            begin
                w = '{a_sel: ASEL_ODD, b_sel: BSEL_LM1, wb: WB_L, jmp: JMP_NEXT,
                      coef_next: 1'b0};
            end
            PC_COMMIT:
            begin
                w = '{a_sel: ASEL_COEF_A, b_sel: BSEL_X, wb: WB_COMMIT, jmp: JMP_LOOP,
                      coef_next: 1'b1};
            end
            PC_FINISH:
            begin
                w = '{a_sel: ASEL_COEF_A, b_sel: BSEL_NONE, wb: WB_FINISH, jmp: JMP_WAIT,
                      coef_next: 1'b0};
            end
            default:
            begin
                w = '{a_sel: ASEL_COEF_A, b_sel: BSEL_NONE, wb: WB_NONE, jmp: JMP_END,
                      coef_next: 1'b0};
            end
        endcase
        return w;
    endfunction

    function automatic longint sat_lim(input longint v, input longint lim);
        longint r;
        r = v;
        if (v > lim)
        begin
            r = lim;
        end
        else if (v < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/legendre_value_derivative_q_eval_core.sv =====
// One request is in progress at a time: in_stall stays high while it runs, until its result
// enters the output register. Each recurrence step passes through the single shared multiplier
// in its MULB, MULAXL, MULODD and COMMIT microcode steps, run by the microcode sequencer.
// A new request is taken while the previous result still waits in the output register.
// Reset: order returns to 2, the sequencer goes idle and the output register empties.
`timescale 1ns / 1ps
`default_nettype none

module legendre_value_derivative_q_eval_core #(
    parameter int MAX_ORDER = lvdq_pkg::DEF_MAX_ORDER
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lvdq_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [lvdq_pkg::DATA_W-1:0]         pwdata,
    output logic      [lvdq_pkg::DATA_W-1:0]         prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [lvdq_pkg::X_W-1:0]     x_coord,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [lvdq_pkg::VAL_W-1:0]        poly_value,
    output logic signed [lvdq_pkg::SLOPE_W-1:0]      poly_slope,
    output logic signed [lvdq_pkg::QV_W-1:0]         q_value,
    output logic signed [lvdq_pkg::QS_W-1:0]         q_slope
);

    import lvdq_pkg::*;

    localparam int KW    = $clog2(MAX_ORDER + 3);
    localparam int DER_W = FRAC_BITS + $clog2((MAX_ORDER + 1) * (MAX_ORDER + 2)) + 2;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(ONE_Q24 / 2);
    localparam logic signed [X_W-1:0]    X_MAX      = X_W'(ONE_Q24);
    localparam logic signed [X_W-1:0]    X_MIN      = -X_W'(ONE_Q24);
    localparam logic signed [L_W-1:0]    L_ONE      = L_W'(ONE_Q24);

    // Coefficient tables a_k = (2k-1)/k and b_k = (k-1)/k in Q24.
    logic [COEF_W-1:0] a_tab [2**KW];
    logic [COEF_W-1:0] b_tab [2**KW];

    for (genvar gk = 0; gk < 2**KW; gk++)
    begin : g_coef
        localparam longint DIV   = (gk == 0) ? 64'sd1 : longint'(gk);
        localparam longint A_VAL = (gk == 0) ? 64'sd0
                                   : ((2 * DIV - 1) * ONE_Q24 + DIV / 2) / DIV;
        localparam longint B_VAL = ((DIV - 1) * ONE_Q24 + DIV / 2) / DIV;
        assign a_tab[gk] = COEF_W'(A_VAL);
        assign b_tab[gk] = COEF_W'(B_VAL);
    end

    logic [ORDER_W-1:0] order_reg;
    logic               busy_reg;
    logic               busy_next;
    logic [PC_W-1:0]    pc_reg;
    logic [PC_W-1:0]    pc_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [KW-1:0]             k_reg;
    logic [KW-1:0]             p_reg;
    logic signed [X_W-1:0]     x_reg;
    logic signed [L_W-1:0]     l_m1_reg;
    logic signed [L_W-1:0]     l_m2_reg;
    logic signed [L_W-1:0]     l_pm1_reg;
    logic signed [L_W-1:0]     l_new_reg;
    logic signed [L_W-1:0]     t_reg;
    logic signed [OPA_W-1:0]   ax_reg;
    logic signed [DER_W-1:0]   d_m1_reg;
    logic signed [DER_W-1:0]   d_m2_reg;
    logic signed [DER_W-1:0]   d_pm1_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    logic signed [VAL_W-1:0]   poly_value_reg;
    logic signed [SLOPE_W-1:0] poly_slope_reg;
    logic signed [QV_W-1:0]    q_value_reg;
    logic signed [QS_W-1:0]    q_slope_reg;

    uc_word_t                  uw;
    logic                      accept;
    logic                      out_free;
    logic [KW-1:0]             p_eff;
    logic [KW-1:0]             coef_idx;
    logic signed [X_W-1:0]     x_clamped;
    logic signed [OPA_W-1:0]   mul_a;
    logic signed [L_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]  rnd_sum;
    logic signed [L_W-1:0]     rnd_l;
    logic signed [DER_W-1:0]   prod_d;
    longint                    q_wide;
    longint                    dq_wide;

    assign uw       = uc_rom(pc_reg);
    assign accept   = in_valid && !busy_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = busy_reg;
    assign pready   = 1'b1;

    always_comb
    begin
        if (32'(order_reg) > MAX_ORDER)
        begin
            p_eff = KW'(MAX_ORDER);
        end
        else
        begin
            p_eff = KW'(order_reg);
        end
    end

    always_comb
    begin
        if (x_coord > X_MAX)
        begin
            x_clamped = X_MAX;
        end
        else if (x_coord < X_MIN)
        begin
            x_clamped = X_MIN;
        end
        else
        begin
            x_clamped = x_coord;
        end
    end

    assign coef_idx = uw.coef_next ? k_reg + KW'(1) : k_reg;

    always_comb
    begin
        case (uw.a_sel)
            ASEL_COEF_A: mul_a = OPA_W'(a_tab[coef_idx]);
            ASEL_COEF_B: mul_a = OPA_W'(b_tab[coef_idx]);
            ASEL_ODD:    mul_a = OPA_W'({k_reg, 1'b0}) - OPA_W'(1);
            ASEL_AX:     mul_a = ax_reg;
            default:     mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (uw.b_sel)
            BSEL_X:   mul_b = L_W'(x_reg);
            BSEL_LM1: mul_b = l_m1_reg;
            BSEL_LM2: mul_b = l_m2_reg;
            default:  mul_b = '0;
        endcase
    end

    assign rnd_sum = prod_reg + ROUND_HALF;
    assign rnd_l   = rnd_sum[FRAC_BITS +: L_W];
    assign prod_d  = prod_reg[DER_W-1:0];
    assign q_wide  = 64'(l_m1_reg) - 64'(l_pm1_reg);
    assign dq_wide = 64'(d_m1_reg) - 64'(d_pm1_reg);

    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = PC_ENTRY;
        end
        else if (busy_reg)
        begin
            case (uw.jmp)
                JMP_NEXT:
                begin
                    pc_next = pc_reg + PC_W'(1);
                end
                JMP_LOOP:
                begin
                    if (k_reg == p_reg + KW'(1))
                    begin
                        pc_next = PC_FINISH;
                    end
                    else
                    begin
                        pc_next = PC_MULB;
                    end
                end
                JMP_WAIT:
                begin
                    if (out_free)
                    begin
                        pc_next        = PC_ENTRY;
                        busy_next      = 1'b0;
                        out_valid_next = 1'b1;
                    end
                end
                default:
                begin
                    pc_next   = PC_ENTRY;
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= ORDER_RESET;
            busy_reg      <= 1'b0;
            pc_reg        <= PC_ENTRY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == REG_ORDER)
            begin
                order_reg <= pwdata[ORDER_W-1:0];
            end
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg     <= x_clamped;
            p_reg     <= p_eff;
            k_reg     <= KW'(1);
            l_m1_reg  <= L_ONE;
            l_m2_reg  <= '0;
            l_pm1_reg <= '0;
            d_m1_reg  <= '0;
            d_m2_reg  <= '0;
            d_pm1_reg <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= mul_a * mul_b;
            case (uw.wb)
                WB_AX:
                begin
                    ax_reg <= rnd_sum[FRAC_BITS +: OPA_W];
                end
                WB_T:
                begin
                    t_reg <= rnd_l;
                end
                WB_L:
                begin
                    l_new_reg <= rnd_l - t_reg;
                end
                WB_COMMIT:
                begin
                    d_m1_reg <= d_m2_reg + prod_d;
                    d_m2_reg <= d_m1_reg;
                    l_m1_reg <= l_new_reg;
                    l_m2_reg <= l_m1_reg;
                    if (k_reg == p_reg)
                    begin
                        l_pm1_reg <= l_m1_reg;
                        d_pm1_reg <= d_m1_reg;
                    end
                    k_reg <= k_reg + KW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && uw.wb == WB_FINISH && out_free)
        begin
            poly_value_reg <= VAL_W'(sat_lim(64'(l_m2_reg), VAL_LIM));
            poly_slope_reg <= SLOPE_W'(sat_lim(64'(d_m2_reg), SLOPE_LIM));
            q_value_reg    <= QV_W'(sat_lim(q_wide, QV_LIM));
            q_slope_reg    <= QS_W'(sat_lim(dq_wide, QS_LIM));
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_ORDER)
        begin
            prdata = DATA_W'(order_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign poly_value = poly_value_reg;
    assign poly_slope = poly_slope_reg;
    assign q_value    = q_value_reg;
    assign q_slope    = q_slope_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && pc_reg == PC_ENTRY && k_reg == KW'(1))
        else $error("Accepted request did not start the program at its entry step.");

    a_no_abort: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && pc_reg != PC_FINISH |=> busy_reg)
        else $error("Sequencer left a request before its finishing step.");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg && pc_reg == PC_FINISH))
        else $error("Result appeared without passing the finishing step.");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && pc_reg != PC_ENTRY |-> k_reg <= p_reg + KW'(2) && pc_reg <= PC_FINISH)
        else $error("Step counter or program counter ran past the program.");

endmodule

`default_nettype wire
